FILE: hdl/vwba_pkg.sv
// ----------------------------------------------------------------------------
// vwba_pkg
// Shared types, command codes and helper functions of the byte-length ALU.
// ----------------------------------------------------------------------------
package vwba_pkg;

  localparam int unsigned MaxBytes = 16;
  localparam int unsigned WordW    = 128;
  localparam int unsigned LenW     = 5;
  localparam int unsigned CmdW     = 4;
  localparam int unsigned ShW      = 8;

  // Command codes.
  localparam logic [CmdW-1:0] CMD_ADD = 4'd0;
  localparam logic [CmdW-1:0] CMD_SUB = 4'd1;
  localparam logic [CmdW-1:0] CMD_MUL = 4'd2;
  localparam logic [CmdW-1:0] CMD_DIV = 4'd3;
  localparam logic [CmdW-1:0] CMD_REM = 4'd4;
  localparam logic [CmdW-1:0] CMD_AND = 4'd5;
  localparam logic [CmdW-1:0] CMD_OR  = 4'd6;
  localparam logic [CmdW-1:0] CMD_XOR = 4'd7;
  localparam logic [CmdW-1:0] CMD_NOT = 4'd8;
  localparam logic [CmdW-1:0] CMD_SHL = 4'd9;
  localparam logic [CmdW-1:0] CMD_SHR = 4'd10;

  // Side information that travels with every word through the pipeline.
  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [LenW-1:0]  len;
    logic             b_zero;
    logic [WordW-1:0] res;
  } side_t;

  // A length of zero reads as one byte, anything above the maximum as the maximum.
  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] l);
    logic [LenW-1:0] r;
    r = l;
    if (l == '0) r = LenW'(1);
    else if (l > LenW'(MaxBytes)) r = LenW'(MaxBytes);
    return r;
  endfunction

  // Mask that keeps the low len bytes of a word.
  function automatic logic [WordW-1:0] len_mask(input logic [LenW-1:0] l);
    logic [WordW-1:0] m;
    if (l >= LenW'(WordW / 8)) m = '1;
    else m = ~({WordW{1'b1}} << {l, 3'b000});
    return m;
  endfunction

endpackage

FILE: hdl/variable_width_byte_alu.sv
// ----------------------------------------------------------------------------
// variable_width_byte_alu
// Pipelined integer ALU over unsigned operands of 1 to 16 bytes.
// ----------------------------------------------------------------------------
// Usage: drive a command word on the operand ports and raise start; the word
// is taken at every rising edge with start high and busy low. busy stays low
// outside of nothing: a new word may enter on every cycle.
// Each result appears for exactly one cycle with result_valid_o high, in the
// order the words were taken. The receiver cannot stall the block.
// Every command takes the same path: one input register, the carry stages in
// which the multiplier and simple operations finish, 128 divider steps (one
// quotient bit each) and an output register. Throughput is one word per cycle.
// Results are truncated to the larger operand length, or to the length of A
// for not and the shifts. A zero divisor gives zero and divide_by_zero_o.
// Reset clears all valid bits, so no result comes out until a word is taken.
// ----------------------------------------------------------------------------
module variable_width_byte_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  command_i,
  input  logic [63:0] operand_a_high_i,
  input  logic [63:0] operand_a_low_i,
  input  logic [4:0]  operand_a_length_i,
  input  logic [63:0] operand_b_high_i,
  input  logic [63:0] operand_b_low_i,
  input  logic [4:0]  operand_b_length_i,
  input  logic [7:0]  shift_amount_i,
  output logic        result_valid_o,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o,
  output logic [4:0]  result_length_o,
  output logic        divide_by_zero_o
);

  localparam int unsigned W     = vwba_pkg::WordW;
  localparam int unsigned LW    = vwba_pkg::LenW;
  localparam int unsigned Steps = vwba_pkg::WordW;

  // Input stage.
  logic                       v1_q;
  logic [W-1:0]               a1_q, b1_q;
  logic [vwba_pkg::CmdW-1:0]  cmd1_q;
  logic [LW-1:0]              len1_q;
  logic [vwba_pkg::ShW-1:0]   sh1_q;
  logic [LW-1:0]              la, lb, len_in;
  logic                       take;

  assign busy = 1'b0;
  assign take = start && !busy;

  always_comb begin
    la = vwba_pkg::clamp_len(operand_a_length_i);
    lb = vwba_pkg::clamp_len(operand_b_length_i);
    len_in = (la >= lb) ? la : lb;
    if (command_i == vwba_pkg::CMD_NOT || command_i == vwba_pkg::CMD_SHL ||
        command_i == vwba_pkg::CMD_SHR) begin
      len_in = la;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q   <= {operand_a_high_i, operand_a_low_i} & vwba_pkg::len_mask(la);
    b1_q   <= {operand_b_high_i, operand_b_low_i} & vwba_pkg::len_mask(lb);
    cmd1_q <= command_i;
    len1_q <= len_in;
    sh1_q  <= shift_amount_i;
  end

  // Simple operations, computed in the second stage.
  logic [W-1:0] simple;

  always_comb begin
    case (cmd1_q)
      vwba_pkg::CMD_ADD: simple = a1_q + b1_q;
      vwba_pkg::CMD_SUB: simple = a1_q - b1_q;
      vwba_pkg::CMD_AND: simple = a1_q & b1_q;
      vwba_pkg::CMD_OR:  simple = a1_q | b1_q;
      vwba_pkg::CMD_XOR: simple = a1_q ^ b1_q;
      vwba_pkg::CMD_NOT: simple = ~a1_q;
      vwba_pkg::CMD_SHL: simple = a1_q << sh1_q;
      vwba_pkg::CMD_SHR: simple = a1_q >> sh1_q;
      default:           simple = '0;
    endcase
  end

  // Multiplier runs alongside stages two to four.
  logic [W-1:0] prod;

  vwba_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (a1_q),
    .b_i    (b1_q),
    .prod_o (prod)
  );

  // Stages two to four carry the operands and side information.
  logic            vp_q [3];
  logic [W-1:0]    ap_q [3];
  logic [W-1:0]    bp_q [3];
  vwba_pkg::side_t sp_q [3];
  vwba_pkg::side_t s2_d, s4_d;

  always_comb begin
    s2_d.cmd    = cmd1_q;
    s2_d.len    = len1_q;
    s2_d.b_zero = (b1_q == '0);
    s2_d.res    = simple;
    s4_d = sp_q[1];
    if (sp_q[1].cmd == vwba_pkg::CMD_MUL) s4_d.res = prod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) vp_q[i] <= 1'b0;
    end else begin
      vp_q[0] <= v1_q;
      vp_q[1] <= vp_q[0];
      vp_q[2] <= vp_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    ap_q[0] <= a1_q;
    bp_q[0] <= b1_q;
    sp_q[0] <= s2_d;
    ap_q[1] <= ap_q[0];
    bp_q[1] <= bp_q[0];
    sp_q[1] <= sp_q[0];
    ap_q[2] <= ap_q[1];
    bp_q[2] <= bp_q[1];
    sp_q[2] <= s4_d;
  end

  // Divider chain, one quotient bit per stage.
  logic            dv   [Steps+1];
  logic [W-1:0]    drem [Steps+1];
  logic [W-1:0]    dnq  [Steps+1];
  logic [W-1:0]    dd   [Steps+1];
  vwba_pkg::side_t ds   [Steps+1];

  assign dv[0]   = vp_q[2];
  assign drem[0] = '0;
  assign dnq[0]  = ap_q[2];
  assign dd[0]   = bp_q[2];
  assign ds[0]   = sp_q[2];

  for (genvar k = 0; k < Steps; k++) begin : g_div
    vwba_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[k]),
      .rem_i   (drem[k]),
      .nq_i    (dnq[k]),
      .d_i     (dd[k]),
      .side_i  (ds[k]),
      .valid_o (dv[k+1]),
      .rem_o   (drem[k+1]),
      .nq_o    (dnq[k+1]),
      .d_o     (dd[k+1]),
      .side_o  (ds[k+1])
    );
  end

  // Final selection, truncation and output register.
  vwba_pkg::side_t last;
  logic            is_div, dz_d;
  logic [W-1:0]    res_d;
  logic            out_v_q, dz_q;
  logic [W-1:0]    res_q;
  logic [LW-1:0]   len_q;

  always_comb begin
    last   = ds[Steps];
    is_div = (last.cmd == vwba_pkg::CMD_DIV) || (last.cmd == vwba_pkg::CMD_REM);
    dz_d   = is_div && last.b_zero;
    res_d  = last.res;
    if (last.cmd == vwba_pkg::CMD_DIV) res_d = dnq[Steps];
    if (last.cmd == vwba_pkg::CMD_REM) res_d = drem[Steps];
    if (dz_d) res_d = '0;
    res_d = res_d & vwba_pkg::len_mask(last.len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= dv[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    len_q <= last.len;
    dz_q  <= dz_d;
  end

  assign result_valid_o   = out_v_q;
  assign result_high_o    = res_q[W-1:64];
  assign result_low_o     = res_q[63:0];
  assign result_length_o  = len_q;
  assign divide_by_zero_o = dz_q;

  // A zero divisor always delivers a zero result.
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && divide_by_zero_o) |-> ({result_high_o, result_low_o} == '0))
    else $error("divide by zero with nonzero result");

  // Result bits above the result length are cleared.
  a_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (({result_high_o, result_low_o} & ~vwba_pkg::len_mask(result_length_o)) == '0))
    else $error("result bits above length");

  // Result length always in the legal range.
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (result_length_o != '0 && result_length_o <= LW'(vwba_pkg::MaxBytes)))
    else $error("result length out of range");

  // An accepted word enters the input stage.
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> v1_q)
    else $error("accepted word lost at input stage");

endmodule

FILE: hdl/vwba_mul.sv
// ----------------------------------------------------------------------------
// vwba_mul
// Truncated 128 x 128 multiplier: 32-bit partial products, then column sums.
// ----------------------------------------------------------------------------
module vwba_mul (
  input  logic                         clk_i,
  input  logic [vwba_pkg::WordW-1:0]   a_i,
  input  logic [vwba_pkg::WordW-1:0]   b_i,
  output logic [vwba_pkg::WordW-1:0]   prod_o
);

  logic [63:0] pp_q [4][4];
  logic [63:0] c0_q;
  logic [64:0] c1_q;
  logic [65:0] c2_q;
  logic [31:0] c3_q;

  // Partial products that land below bit 128.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (i + j < 4) begin
          pp_q[i][j] <= 64'(a_i[32*i +: 32]) * 64'(b_i[32*j +: 32]);
        end else begin
          pp_q[i][j] <= '0;
        end
      end
    end
  end

  // Column sums; only the low 32 bits of the top column survive truncation.
  always_ff @(posedge clk_i) begin
    c0_q <= pp_q[0][0];
    c1_q <= 65'(pp_q[0][1]) + 65'(pp_q[1][0]);
    c2_q <= 66'(pp_q[0][2]) + 66'(pp_q[1][1]) + 66'(pp_q[2][0]);
    c3_q <= pp_q[0][3][31:0] + pp_q[1][2][31:0] + pp_q[2][1][31:0] + pp_q[3][0][31:0];
  end

  // Final alignment and sum.
  assign prod_o = 128'(c0_q) + (128'(c1_q) << 32) + (128'(c2_q) << 64)
                + (128'(c3_q) << 96);

endmodule

FILE: hdl/vwba_div_stage.sv
// ----------------------------------------------------------------------------
// vwba_div_stage
// One registered step of a restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vwba_div_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [vwba_pkg::WordW-1:0]  rem_i,
  input  logic [vwba_pkg::WordW-1:0]  nq_i,
  input  logic [vwba_pkg::WordW-1:0]  d_i,
  input  vwba_pkg::side_t             side_i,
  output logic                        valid_o,
  output logic [vwba_pkg::WordW-1:0]  rem_o,
  output logic [vwba_pkg::WordW-1:0]  nq_o,
  output logic [vwba_pkg::WordW-1:0]  d_o,
  output vwba_pkg::side_t             side_o
);

  localparam int unsigned W = vwba_pkg::WordW;

  logic          valid_q;
  logic [W-1:0]  rem_q, rem_d, nq_q, d_q, t;
  vwba_pkg::side_t side_q;
  logic          ge;

  // Shift in the next numerator bit and try the subtraction.
  always_comb begin
    t     = {rem_i[W-2:0], nq_i[W-1]};
    ge    = rem_i[W-1] | (t >= d_i);
    rem_d = ge ? (t - d_i) : t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    nq_q   <= {nq_i[W-2:0], ge};
    d_q    <= d_i;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign d_o     = d_q;
  assign side_o  = side_q;

endmodule

FILE: dv/tb_variable_width_byte_alu.sv
// ----------------------------------------------------------------------------
// tb_variable_width_byte_alu
// Self-checking testbench for the pipelined byte-length ALU. A queue of
// command words, directed corner cases first and then random words, feeds a
// clocked driver. A model of the ALU predicts every result when its word is
// taken, and a clocked monitor checks each strobed result in order.
// ----------------------------------------------------------------------------
module tb_variable_width_byte_alu;

  typedef struct {
    logic [3:0]   cmd;
    logic [127:0] a;
    logic [4:0]   la;
    logic [127:0] b;
    logic [4:0]   lb;
    logic [7:0]   sh;
  } alu_word_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  len;
    logic        dz;
  } alu_result_t;

  localparam int unsigned RandWords = 1150;
  localparam int unsigned DrainWord = 600;
  localparam int unsigned TailCycles = 160;
  localparam int unsigned WatchdogLimit = 3000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [3:0]  command_i;
  logic [63:0] operand_a_high_i;
  logic [63:0] operand_a_low_i;
  logic [4:0]  operand_a_length_i;
  logic [63:0] operand_b_high_i;
  logic [63:0] operand_b_low_i;
  logic [4:0]  operand_b_length_i;
  logic [7:0]  shift_amount_i;
  logic        result_valid_o;
  logic [63:0] result_high_o;
  logic [63:0] result_low_o;
  logic [4:0]  result_length_o;
  logic        divide_by_zero_o;

  alu_word_t   pending_words[$];
  alu_result_t expected_results[$];
  alu_word_t   driven_word;
  int unsigned words_taken;
  int unsigned total_words;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          draining;

  variable_width_byte_alu uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .command_i          (command_i),
    .operand_a_high_i   (operand_a_high_i),
    .operand_a_low_i    (operand_a_low_i),
    .operand_a_length_i (operand_a_length_i),
    .operand_b_high_i   (operand_b_high_i),
    .operand_b_low_i    (operand_b_low_i),
    .operand_b_length_i (operand_b_length_i),
    .shift_amount_i     (shift_amount_i),
    .result_valid_o     (result_valid_o),
    .result_high_o      (result_high_o),
    .result_low_o       (result_low_o),
    .result_length_o    (result_length_o),
    .divide_by_zero_o   (divide_by_zero_o)
  );

  // Clock with a period of 10.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Lengths of zero read as one byte, lengths above 16 as 16.
  function automatic logic [4:0] fit_len(input logic [4:0] l);
    if (l == 5'd0) return 5'd1;
    if (l > 5'(vwba_pkg::MaxBytes)) return 5'(vwba_pkg::MaxBytes);
    return l;
  endfunction

  // Keeps the low n bytes of a value.
  function automatic logic [127:0] low_bytes(input logic [127:0] v, input logic [4:0] n);
    if (n >= 5'd16) return v;
    return v & ((128'd1 << (n * 8)) - 128'd1);
  endfunction

  // Computes the result of one command word.
  function automatic alu_result_t alu_outcome(input alu_word_t w);
    logic [4:0]   la, lb, len;
    logic [127:0] a, b, r;
    alu_result_t  o;
    la = fit_len(w.la);
    lb = fit_len(w.lb);
    len = (la >= lb) ? la : lb;
    a = low_bytes(w.a, la);
    b = low_bytes(w.b, lb);
    r = '0;
    o.dz = 1'b0;
    case (w.cmd)
      vwba_pkg::CMD_ADD: r = a + b;
      vwba_pkg::CMD_SUB: r = a - b;
      vwba_pkg::CMD_MUL: r = a * b;
      vwba_pkg::CMD_DIV, vwba_pkg::CMD_REM: begin
        if (b == '0) o.dz = 1'b1;
        else r = (w.cmd == vwba_pkg::CMD_DIV) ? a / b : a % b;
      end
      vwba_pkg::CMD_AND: r = a & b;
      vwba_pkg::CMD_OR:  r = a | b;
      vwba_pkg::CMD_XOR: r = a ^ b;
      vwba_pkg::CMD_NOT: begin
        r = ~a;
        len = la;
      end
      vwba_pkg::CMD_SHL: begin
        r = (w.sh >= 8'd128) ? '0 : a << w.sh;
        len = la;
      end
      vwba_pkg::CMD_SHR: begin
        r = (w.sh >= 8'd128) ? '0 : a >> w.sh;
        len = la;
      end
      default: r = '0;
    endcase
    r = low_bytes(r, len);
    o.hi = r[127:64];
    o.lo = r[63:0];
    o.len = len;
    return o;
  endfunction

  task automatic queue_word(input logic [3:0] cmd, input logic [127:0] a, input logic [4:0] la,
                            input logic [127:0] b, input logic [4:0] lb, input logic [7:0] sh);
    alu_word_t w;
    w.cmd = cmd;
    w.a = a;
    w.la = la;
    w.b = b;
    w.lb = lb;
    w.sh = sh;
    pending_words.push_back(w);
  endtask

  function automatic logic [127:0] rand_operand();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick == 2) return 128'($urandom_range(3));
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [4:0] rand_len();
    if ($urandom_range(9) == 0) return 5'($urandom_range(31));
    if ($urandom_range(3) == 0) return 5'd16;
    return 5'($urandom_range(1, 16));
  endfunction

  // Stimulus and end of run.
  initial begin
    logic [3:0]   cmd;
    logic [127:0] b;
    logic [7:0]   sh;
    rst_ni = 1'b0;
    // Directed corner cases.
    queue_word(vwba_pkg::CMD_ADD, '1, 5'd16, '1, 5'd16, 8'd0);
    queue_word(vwba_pkg::CMD_ADD, '1, 5'd1, 128'd1, 5'd1, 8'd0);
    queue_word(vwba_pkg::CMD_SUB, '0, 5'd16, 128'd1, 5'd16, 8'd0);
    queue_word(vwba_pkg::CMD_SUB, 128'h1234, 5'd2, '1, 5'd16, 8'd0);
    queue_word(vwba_pkg::CMD_MUL, '1, 5'd16, '1, 5'd16, 8'd0);
    queue_word(vwba_pkg::CMD_MUL, '1, 5'd8, '1, 5'd8, 8'd0);
    queue_word(vwba_pkg::CMD_DIV, '1, 5'd16, '0, 5'd16, 8'd0);
    queue_word(vwba_pkg::CMD_REM, '1, 5'd16, {64'd0, 64'hff00}, 5'd1, 8'd0);
    queue_word(vwba_pkg::CMD_DIV, '1, 5'd16, 128'd7, 5'd3, 8'd0);
    queue_word(vwba_pkg::CMD_REM, '1, 5'd16, 128'd7, 5'd3, 8'd0);
    queue_word(vwba_pkg::CMD_DIV, 128'd5, 5'd1, '1, 5'd16, 8'd0);
    queue_word(vwba_pkg::CMD_AND, '1, 5'd16, {64'haaaa, 64'h5555}, 5'd9, 8'd0);
    queue_word(vwba_pkg::CMD_OR, '0, 5'd0, '1, 5'd31, 8'd0);
    queue_word(vwba_pkg::CMD_XOR, '1, 5'd17, '1, 5'd5, 8'd0);
    queue_word(vwba_pkg::CMD_NOT, '0, 5'd16, '1, 5'd1, 8'd0);
    queue_word(vwba_pkg::CMD_NOT, '0, 5'd0, '1, 5'd16, 8'd0);
    queue_word(vwba_pkg::CMD_SHL, '1, 5'd16, '0, 5'd1, 8'd0);
    queue_word(vwba_pkg::CMD_SHL, '1, 5'd16, '0, 5'd1, 8'd127);
    queue_word(vwba_pkg::CMD_SHL, '1, 5'd16, '0, 5'd1, 8'd128);
    queue_word(vwba_pkg::CMD_SHR, '1, 5'd16, '0, 5'd1, 8'd64);
    queue_word(vwba_pkg::CMD_SHR, '1, 5'd16, '0, 5'd1, 8'd255);
    queue_word(4'd11, '1, 5'd3, '1, 5'd12, 8'd0);
    queue_word(4'd15, '1, 5'd16, '1, 5'd16, 8'd255);
    // Random words, mostly valid commands with a few unused codes.
    for (int unsigned i = 0; i < RandWords; i++) begin
      cmd = ($urandom_range(19) == 0) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(10));
      b = rand_operand();
      sh = ($urandom_range(7) == 0) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(127));
      queue_word(cmd, rand_operand(), rand_len(), b, rand_len(), sh);
    end
    total_words = pending_words.size();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Wait for every word to be taken and every result to be checked.
    while (pending_words.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Driver: takes the next word from the queue, idling at random by phase and pausing once to drain.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned idle_pct;
    bit          send;
    if (!rst_ni) begin
      start <= 1'b0;
      command_i <= '0;
      operand_a_high_i <= '0;
      operand_a_low_i <= '0;
      operand_a_length_i <= '0;
      operand_b_high_i <= '0;
      operand_b_low_i <= '0;
      operand_b_length_i <= '0;
      shift_amount_i <= '0;
      words_taken = 0;
      draining = 1'b0;
    end else begin
      send = 1'b0;
      if (start && !busy) begin
        expected_results.push_back(alu_outcome(driven_word));
        words_taken = words_taken + 1;
        if (words_taken == DrainWord) draining = 1'b1;
      end else if (draining && expected_results.size() == 0) begin
        draining = 1'b0;
      end
      if (start && busy) begin
        send = 1'b0;
      end else if (!draining && pending_words.size() != 0) begin
        if (words_taken < total_words / 3) idle_pct = 7;
        else if (words_taken < 2 * total_words / 3) idle_pct = 63;
        else idle_pct = 0;
        send = ($urandom_range(99) >= idle_pct);
      end
      if (send) begin
        driven_word = pending_words.pop_front();
        command_i <= driven_word.cmd;
        operand_a_high_i <= driven_word.a[127:64];
        operand_a_low_i <= driven_word.a[63:0];
        operand_a_length_i <= driven_word.la;
        operand_b_high_i <= driven_word.b[127:64];
        operand_b_low_i <= driven_word.b[63:0];
        operand_b_length_i <= driven_word.lb;
        shift_amount_i <= driven_word.sh;
      end
      // A word held against busy keeps start high.
      start <= send || (start && busy);
    end
  end

  // Monitor: checks each strobed result against the oldest prediction.
  always @(posedge clk_i) begin
    alu_result_t exp_r;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result hi=%h lo=%h len=%0d dz=%b", result_high_o,
                     result_low_o, result_length_o, divide_by_zero_o);
        end else begin
          exp_r = expected_results.pop_front();
          if (result_high_o !== exp_r.hi || result_low_o !== exp_r.lo ||
              result_length_o !== exp_r.len || divide_by_zero_o !== exp_r.dz) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp hi=%h lo=%h len=%0d dz=%b got hi=%h lo=%h len=%0d dz=%b",
                       exp_r.hi, exp_r.lo, exp_r.len, exp_r.dz, result_high_o,
                       result_low_o, result_length_o, divide_by_zero_o);
          end
        end
      end
      // Watchdog on cycles in which no word moves either way.
      if ((start && !busy) || result_valid_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
      mismatches = 0;
    end
  end

endmodule
